// File: hdl/binary_to_bcd_display_digits_top_assert.svh
// assertion macros for the binary to bcd display digit converter
// used by binary_to_bcd_display_digits_top.sv, no other dependencies
`ifndef BINARY_TO_BCD_DISPLAY_DIGITS_TOP_ASSERT_SVH
`define BINARY_TO_BCD_DISPLAY_DIGITS_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define BCDD_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bcdd assertion failed");

// next-cycle implication
`define BCDD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bcdd assertion failed");

`else

`define BCDD_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define BCDD_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: hdl/bcdd_pkg.sv
// types, constants and double-dabble helper functions for the bcd display converter
// no dependencies
`timescale 1ns / 1ps

package bcdd_pkg;

   localparam int VALUE_W        = 32;
   localparam int BCD_W          = 32;
   localparam int EN_W           = 8;
   localparam int DIGIT_W        = 4;
   localparam int MAX_DIGITS     = 10;
   localparam int OUT_DIGITS     = BCD_W / DIGIT_W;
   localparam int NUM_STAGES     = 4;
   localparam int BITS_PER_STAGE = VALUE_W / NUM_STAGES;

   localparam logic [DIGIT_W-1:0] ADJ_LIMIT = DIGIT_W'(5);
   localparam logic [DIGIT_W-1:0] ADJ_ADD   = DIGIT_W'(3);
   localparam logic [DIGIT_W-1:0] DIGIT_MAX = DIGIT_W'(9);

   typedef logic [MAX_DIGITS*DIGIT_W-1:0] digits_type;

   typedef struct packed {
      digits_type         bcd;
      logic [VALUE_W-1:0] bin;
   } dabble_type;

   // one add-3 and shift step
   function automatic digits_type dabble_step(digits_type bcd, logic msb);
      digits_type         adj;
      logic [DIGIT_W-1:0] d;
      adj = bcd;
      for (int k = 0; k < MAX_DIGITS; k++) begin
         d = bcd[k*DIGIT_W +: DIGIT_W];
         if (d >= ADJ_LIMIT) begin
            adj[k*DIGIT_W +: DIGIT_W] = d + ADJ_ADD;
         end
      end
      return {adj[MAX_DIGITS*DIGIT_W-2:0], msb};
   endfunction

   // one pipeline stage worth of input bits
   function automatic dabble_type dabble_stage(dabble_type s);
      dabble_type r;
      r = s;
      for (int i = 0; i < BITS_PER_STAGE; i++) begin
         r.bcd = dabble_step(r.bcd, r.bin[VALUE_W-1]);
         r.bin = {r.bin[VALUE_W-2:0], 1'b0};
      end
      return r;
   endfunction

   function automatic logic bcd_digits_ok(logic [BCD_W-1:0] b);
      logic ok;
      ok = 1'b1;
      for (int k = 0; k < OUT_DIGITS; k++) begin
         if (b[k*DIGIT_W +: DIGIT_W] > DIGIT_MAX) begin
            ok = 1'b0;
         end
      end
      return ok;
   endfunction

endpackage

// File: hdl/binary_to_bcd_display_digits_top.sv
// channel  dir  ports                                    beat
// req      in   req_valid req_stall req_value            one 32-bit binary value
// rsp      out  rsp_valid rsp_stall rsp_bcd_digits       packed bcd + active-low enables
//                rsp_digit_enable_n
// one beat accepted per cycle unless req_stall is high; four double-dabble stages of eight
// bits each, then the enable / truncation stage
// reset is synchronous and clears only the stage and output valid bits
// rsp_stall holds the output register and backs up through per-stage ready, so
// empty stages still fill while the output is stalled
// depends on bcdd_pkg and binary_to_bcd_display_digits_top_assert.svh
`timescale 1ns / 1ps
`include "binary_to_bcd_display_digits_top_assert.svh"

module binary_to_bcd_display_digits_top #(
   parameter int NUM_DIGITS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [bcdd_pkg::VALUE_W-1:0]  req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [bcdd_pkg::BCD_W-1:0]    rsp_bcd_digits,
   output logic [bcdd_pkg::EN_W-1:0]     rsp_digit_enable_n
);

   import bcdd_pkg::*;

   localparam int LAST = NUM_STAGES - 1;

   logic [NUM_STAGES-1:0] st_valid_ff;
   logic [NUM_STAGES-1:0] st_valid_in;
   logic [NUM_STAGES-1:0] st_ready;
   dabble_type            st_ff [NUM_STAGES];
   dabble_type            st_in [NUM_STAGES];

   logic                  rsp_valid_ff;
   logic                  rsp_ready;
   logic [BCD_W-1:0]      rsp_bcd_digits_ff;
   logic [BCD_W-1:0]      rsp_bcd_digits_in;
   logic [EN_W-1:0]       rsp_digit_enable_n_ff;
   logic [EN_W-1:0]       rsp_digit_enable_n_in;

   logic [MAX_DIGITS-1:0] above_nz;
   digits_type            last_bcd;

   logic [EN_W-1:0]       rsp_lit;
   logic [EN_W-1:0]       rsp_lit_inc;
   logic                  dark_zero;

   // ready chain
   assign rsp_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      st_ready[LAST] = !st_valid_ff[LAST] || rsp_ready;
      for (int i = LAST - 1; i >= 0; i--) begin
         st_ready[i] = !st_valid_ff[i] || st_ready[i+1];
      end
   end

   assign req_stall = !st_ready[0];

   // dabble stages
   always_comb begin
      st_in[0]       = dabble_stage('{bcd: '0, bin: req_value});
      st_valid_in[0] = req_valid;
      for (int i = 1; i < NUM_STAGES; i++) begin
         st_in[i]       = dabble_stage(st_ff[i-1]);
         st_valid_in[i] = st_valid_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_valid_ff <= '0;
      end else begin
         for (int i = 0; i < NUM_STAGES; i++) begin
            if (st_ready[i]) begin
               st_valid_ff[i] <= st_valid_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_STAGES; i++) begin
         if (st_ready[i] && st_valid_in[i]) begin
            st_ff[i] <= st_in[i];
         end
      end
   end

   // digit select and enable mask
   assign last_bcd = st_ff[LAST].bcd;

   always_comb begin
      above_nz[MAX_DIGITS-1] = |last_bcd[(MAX_DIGITS-1)*DIGIT_W +: DIGIT_W];
      for (int k = MAX_DIGITS - 2; k >= 0; k--) begin
         above_nz[k] = above_nz[k+1] | (|last_bcd[k*DIGIT_W +: DIGIT_W]);
      end
   end

   always_comb begin
      rsp_bcd_digits_in     = '0;
      rsp_digit_enable_n_in = '1;
      for (int k = 0; k < OUT_DIGITS; k++) begin
         if (k < NUM_DIGITS) begin
            rsp_bcd_digits_in[k*DIGIT_W +: DIGIT_W] = last_bcd[k*DIGIT_W +: DIGIT_W];
            rsp_digit_enable_n_in[k]                = !above_nz[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_ready) begin
         rsp_valid_ff <= st_valid_ff[LAST];
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_ready && st_valid_ff[LAST]) begin
         rsp_bcd_digits_ff     <= rsp_bcd_digits_in;
         rsp_digit_enable_n_ff <= rsp_digit_enable_n_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_bcd_digits     = rsp_bcd_digits_ff;
   assign rsp_digit_enable_n = rsp_digit_enable_n_ff;

   // checks
   assign rsp_lit     = ~rsp_digit_enable_n_ff;
   assign rsp_lit_inc = rsp_lit + EN_W'(1);

   always_comb begin
      dark_zero = 1'b1;
      for (int k = 0; k < OUT_DIGITS; k++) begin
         if (rsp_digit_enable_n_ff[k] && (|rsp_bcd_digits_ff[k*DIGIT_W +: DIGIT_W])) begin
            dark_zero = 1'b0;
         end
      end
   end

   `BCDD_ASSERT_IMPLIES(a_digits_decimal, clock, reset, rsp_valid_ff, bcd_digits_ok(rsp_bcd_digits_ff))
   `BCDD_ASSERT_IMPLIES(a_enable_contiguous, clock, reset, rsp_valid_ff, (rsp_lit & rsp_lit_inc) == '0)
   `BCDD_ASSERT_IMPLIES(a_dark_digits_zero, clock, reset, rsp_valid_ff, dark_zero)
   `BCDD_ASSERT_NEXT(a_accept_enters_pipe, clock, reset, req_valid && !req_stall, st_valid_ff[0])

endmodule
